// ----- hdl/acache_pkg.sv -----
// ----------------------------------------------------------------------------
// acache_pkg
// shared types and constants of the associative arp cache
// ----------------------------------------------------------------------------
`default_nettype none

package acache_pkg;

  // default number of table entries
  localparam int unsigned DefaultEntries = 16;

  // field widths
  localparam int unsigned IpW  = 32;
  localparam int unsigned MacW = 48;

  // request type codes
  localparam logic ReqStore  = 1'b0;
  localparam logic ReqLookup = 1'b1;

  // result outcome codes
  typedef enum logic [2:0] {
    OUT_LOOKUP_HIT     = 3'd0,
    OUT_LOOKUP_MISS    = 3'd1,
    OUT_STORE_UPDATED  = 3'd2,
    OUT_STORE_INSERTED = 3'd3,
    OUT_STORE_DROPPED  = 3'd4
  } outcome_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MAC_WAIT
  } state_e;

  // request word
  typedef struct packed {
    logic            req_type;
    logic [IpW-1:0]  ip_addr;
    logic [MacW-1:0] hw_addr;
  } req_t;

  // result word
  typedef struct packed {
    outcome_e        outcome;
    logic [MacW-1:0] found_hw_addr;
  } rsp_t;

  // memory port enables from the controller
  typedef struct packed {
    logic key_re;
    logic key_we;
    logic mac_re;
    logic mac_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/acache_store.sv -----
// ----------------------------------------------------------------------------
// acache_store
// key and mac memories, one write and one registered read per cycle each
// ----------------------------------------------------------------------------
`default_nettype none

module acache_store #(
  parameter int unsigned TableEntries = acache_pkg::DefaultEntries,
  localparam int unsigned IdxW        = $clog2(TableEntries)
) (
  input  logic                        clk_i,
  input  acache_pkg::mem_ctl_t        ctl_i,
  input  logic [IdxW-1:0]             key_raddr_i,
  input  logic [IdxW-1:0]             mac_raddr_i,
  input  logic [IdxW-1:0]             waddr_i,
  input  logic [acache_pkg::IpW-1:0]  key_wdata_i,
  input  logic [acache_pkg::MacW-1:0] mac_wdata_i,
  output logic [acache_pkg::IpW-1:0]  key_rdata_o,
  output logic [acache_pkg::MacW-1:0] mac_rdata_o
);
  import acache_pkg::*;

  logic [IpW-1:0]  key_mem [TableEntries];
  logic [MacW-1:0] mac_mem [TableEntries];

  // key memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.key_we) begin
      key_mem[waddr_i] <= key_wdata_i;
    end
    if (ctl_i.key_re) begin
      key_rdata_o <= key_mem[key_raddr_i];
    end
  end

  // mac memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.mac_we) begin
      mac_mem[waddr_i] <= mac_wdata_i;
    end
    if (ctl_i.mac_re) begin
      mac_rdata_o <= mac_mem[mac_raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/acache_ctrl.sv -----
// ----------------------------------------------------------------------------
// acache_ctrl
// request sequencer: serial key scan, free slot tracking, valid marks, result
// ----------------------------------------------------------------------------
`default_nettype none

module acache_ctrl #(
  parameter int unsigned TableEntries = acache_pkg::DefaultEntries,
  localparam int unsigned IdxW        = $clog2(TableEntries)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  acache_pkg::req_t            req_i,
  output logic                        busy_o,
  output logic                        done_o,
  output acache_pkg::rsp_t            rsp_o,
  output acache_pkg::mem_ctl_t        ctl_o,
  output logic [IdxW-1:0]             key_raddr_o,
  output logic [IdxW-1:0]             mac_raddr_o,
  output logic [IdxW-1:0]             waddr_o,
  output logic [acache_pkg::IpW-1:0]  key_wdata_o,
  output logic [acache_pkg::MacW-1:0] mac_wdata_o,
  input  logic [acache_pkg::IpW-1:0]  key_rdata_i,
  input  logic [acache_pkg::MacW-1:0] mac_rdata_i
);
  import acache_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  state_e              state_q, state_d;
  req_t                req_q;
  logic [IdxW-1:0]     scan_q;
  logic                iss_end_q;
  logic                cmp_vld_q;
  logic                cmp_last_q;
  logic [IdxW-1:0]     cmp_idx_q;
  logic                free_vld_q;
  logic [IdxW-1:0]     free_idx_q;
  logic [TableEntries-1:0] valid_q;
  logic                done_q, done_d;
  rsp_t                rsp_q, rsp_d;

  logic accept;
  logic issue;
  logic key_hit;
  logic scan_end;
  logic set_valid;

  assign accept   = (state_q == ST_IDLE) && start_i;
  assign issue    = (state_q == ST_SCAN) && !iss_end_q;
  assign key_hit  = cmp_vld_q && valid_q[cmp_idx_q] && (key_rdata_i == req_q.ip_addr);
  assign scan_end = (state_q == ST_SCAN) && cmp_vld_q && (key_hit || cmp_last_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (key_hit && (req_q.req_type == ReqLookup)) state_d = ST_MAC_WAIT;
          else                                          state_d = ST_IDLE;
        end
      end
      ST_MAC_WAIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // memory accesses and result word
  always_comb begin
    ctl_o         = '0;
    key_raddr_o   = scan_q;
    mac_raddr_o   = cmp_idx_q;
    waddr_o       = cmp_idx_q;
    key_wdata_o   = req_q.ip_addr;
    mac_wdata_o   = req_q.hw_addr;
    set_valid     = 1'b0;
    done_d        = 1'b0;
    rsp_d.outcome       = OUT_LOOKUP_MISS;
    rsp_d.found_hw_addr = '0;
    case (state_q)
      ST_SCAN: begin
        ctl_o.key_re = issue;
        if (scan_end) begin
          if (key_hit) begin
            if (req_q.req_type == ReqLookup) begin
              ctl_o.mac_re = 1'b1;
            end else begin
              ctl_o.mac_we  = 1'b1;
              done_d        = 1'b1;
              rsp_d.outcome = OUT_STORE_UPDATED;
            end
          end else if (req_q.req_type == ReqLookup) begin
            done_d        = 1'b1;
            rsp_d.outcome = OUT_LOOKUP_MISS;
          end else if (free_vld_q) begin
            waddr_o       = free_idx_q;
            ctl_o.key_we  = 1'b1;
            ctl_o.mac_we  = 1'b1;
            set_valid     = 1'b1;
            done_d        = 1'b1;
            rsp_d.outcome = OUT_STORE_INSERTED;
          end else begin
            done_d        = 1'b1;
            rsp_d.outcome = OUT_STORE_DROPPED;
          end
        end
      end
      ST_MAC_WAIT: begin
        done_d              = 1'b1;
        rsp_d.outcome       = OUT_LOOKUP_HIT;
        rsp_d.found_hw_addr = mac_rdata_i;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_q     <= '0;
      iss_end_q  <= 1'b0;
      cmp_vld_q  <= 1'b0;
      cmp_last_q <= 1'b0;
      free_vld_q <= 1'b0;
      valid_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (accept) begin
        scan_q     <= '0;
        iss_end_q  <= 1'b0;
        cmp_vld_q  <= 1'b0;
        cmp_last_q <= 1'b0;
        free_vld_q <= 1'b0;
      end else begin
        cmp_vld_q  <= issue;
        cmp_last_q <= (scan_q == LastIdx);
        if (issue) begin
          if (scan_q == LastIdx) iss_end_q <= 1'b1;
          else                   scan_q    <= scan_q + 1'b1;
          if (!free_vld_q && !valid_q[scan_q]) free_vld_q <= 1'b1;
        end
      end
      if (set_valid) valid_q[free_idx_q] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    if (issue) cmp_idx_q <= scan_q;
    if (issue && !free_vld_q && !valid_q[scan_q]) free_idx_q <= scan_q;
    if (done_d) rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ----- hdl/arp_cache_table_top.sv -----
// ----------------------------------------------------------------------------
// arp_cache_table_top
// associative arp cache: ipv4 address to mac address, store and lookup
// ----------------------------------------------------------------------------
//  channel   | handshake         | word
//  ----------+-------------------+--------------------------------------------
//  request   | start_i / busy_o  | req_i  (req_type, ip_addr, hw_addr)
//  result    | done_o (strobe)   | rsp_o  (outcome, found_hw_addr)
//
//  a request is taken when start_i is high and busy_o is low; each key is read
//  from the key memory one entry a cycle, and the scan stops early on a match;
//  a lookup hit then reads the mac memory before the result strobe is shown.
//  busy_o falls in the cycle the result strobe is shown.
//  reset clears all valid marks and the sequencer; memory contents are kept.
//  the result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_table_top #(
  parameter int unsigned TableEntries = acache_pkg::DefaultEntries
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  acache_pkg::req_t req_i,
  output logic             busy_o,
  output logic             done_o,
  output acache_pkg::rsp_t rsp_o
);
  import acache_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);

  mem_ctl_t        mem_ctl;
  logic [IdxW-1:0] key_raddr;
  logic [IdxW-1:0] mac_raddr;
  logic [IdxW-1:0] waddr;
  logic [IpW-1:0]  key_wdata;
  logic [MacW-1:0] mac_wdata;
  logic [IpW-1:0]  key_rdata;
  logic [MacW-1:0] mac_rdata;

  // sequencer
  acache_ctrl #(
    .TableEntries(TableEntries)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .ctl_o       (mem_ctl),
    .key_raddr_o (key_raddr),
    .mac_raddr_o (mac_raddr),
    .waddr_o     (waddr),
    .key_wdata_o (key_wdata),
    .mac_wdata_o (mac_wdata),
    .key_rdata_i (key_rdata),
    .mac_rdata_i (mac_rdata)
  );

  // table memories
  acache_store #(
    .TableEntries(TableEntries)
  ) u_store (
    .clk_i       (clk_i),
    .ctl_i       (mem_ctl),
    .key_raddr_i (key_raddr),
    .mac_raddr_i (mac_raddr),
    .waddr_i     (waddr),
    .key_wdata_i (key_wdata),
    .mac_wdata_i (mac_wdata),
    .key_rdata_o (key_rdata),
    .mac_rdata_o (mac_rdata)
  );

endmodule

`default_nettype wire

// ----- hdl/acache_chk.sv -----
// ----------------------------------------------------------------------------
// acache_chk
// port level checks of the arp cache, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module acache_chk (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input wire logic             done_o,
  input wire acache_pkg::rsp_t rsp_o
);
  import acache_pkg::*;

  // a taken request makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request taken but block not busy");

  // the result word is shown once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // busy ends only with a result
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy ended without a result");

  // never two results in a row
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // mac field is zero unless a lookup hit
  a_mac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.outcome != OUT_LOOKUP_HIT) |-> (rsp_o.found_hw_addr == '0))
    else $error("mac field not zero on a non hit result");

endmodule

bind arp_cache_table_top acache_chk u_acache_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);

`default_nettype wire
